[sv/xed_pkg.sv]
// ----------------------------------------------------------------------------
// XML entity decoder package
// Shared constants, entity tables and the command type between front and back.
// ----------------------------------------------------------------------------
package xed_pkg;

    localparam int EntCount  = 5;
    localparam int EntMaxLen = 6;
    localparam int HoldDepth = 5;
    localparam int CntW      = 3;
    localparam int QDepth    = 4;
    localparam int QPtrW     = 2;
    localparam int QCntW     = 3;

    localparam logic [7:0] ChAmp  = 8'h26;
    localparam logic [7:0] ChCr   = 8'h0D;
    localparam logic [7:0] ChTerm = 8'h00;

    // Entity spellings, padded with zeros past their length.
    localparam logic [7:0] EntChars [EntCount][EntMaxLen] = '{
        '{"&", "g", "t", ";", 8'h00, 8'h00},
        '{"&", "l", "t", ";", 8'h00, 8'h00},
        '{"&", "q", "u", "o", "t", ";"},
        '{"&", "a", "p", "o", "s", ";"},
        '{"&", "a", "m", "p", ";", 8'h00}
    };

    localparam logic [CntW-1:0] EntLen [EntCount] = '{3'd4, 3'd4, 3'd6, 3'd6, 3'd5};

    localparam logic [7:0] EntRepl [EntCount] = '{8'h3E, 8'h3C, 8'h22, 8'h27, 8'h26};

    // One queued command: flush held_cnt held bytes, then optionally one byte,
    // then optionally the terminator.
    typedef struct packed {
        logic [HoldDepth-1:0][7:0] held;
        logic [CntW-1:0]           held_cnt;
        logic                      emit_en;
        logic [7:0]                emit_byte;
        logic                      term;
    } t_cmd;

endpackage

[sv/xed_front.sv]
// ----------------------------------------------------------------------------
// XML entity decoder front end
// Matches each input byte against the entity table and issues at most one command.
// ----------------------------------------------------------------------------
module xed_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_final,
    input  logic          i_q_full,
    output logic          o_ready,
    output logic          o_push,
    output xed_pkg::t_cmd o_cmd
);

    logic [7:0]                   r_held [xed_pkg::HoldDepth];
    logic [xed_pkg::CntW-1:0]     r_cnt;
    logic [xed_pkg::EntCount-1:0] r_alive;

    logic [xed_pkg::CntW-1:0]     n_cnt;
    logic [xed_pkg::EntCount-1:0] n_alive;

    logic [xed_pkg::CntW-1:0]     cl;
    logic [xed_pkg::EntCount-1:0] match;
    logic [xed_pkg::EntCount-1:0] len_eq;
    logic                         full_hit;
    logic                         prefix_hit;
    logic [7:0]                   repl;
    logic                         wr_en;
    logic [xed_pkg::CntW-1:0]     wr_idx;
    logic                         accept;
    xed_pkg::t_cmd                cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign cl      = r_cnt + xed_pkg::CntW'(1);

    always_comb begin
        repl = 8'h00;
        for (int k = 0; k < xed_pkg::EntCount; k++) begin
            len_eq[k] = (cl == xed_pkg::EntLen[k]);
            match[k]  = r_alive[k] && (cl <= xed_pkg::EntLen[k]) &&
                        (xed_pkg::EntChars[k][r_cnt] == i_byte);
            if (match[k] && len_eq[k]) begin
                repl = xed_pkg::EntRepl[k];
            end
        end
        full_hit   = |(match & len_eq);
        prefix_hit = |(match & ~len_eq);
    end

    always_comb begin
        for (int i = 0; i < xed_pkg::HoldDepth; i++) begin
            cmd.held[i] = r_held[i];
        end
        cmd.held_cnt  = '0;
        cmd.emit_en   = 1'b0;
        cmd.emit_byte = i_byte;
        cmd.term      = i_final;
        n_cnt         = '0;
        n_alive       = r_alive;
        wr_en         = 1'b0;
        wr_idx        = '0;

        if (r_cnt != '0 && full_hit) begin
            cmd.emit_en   = 1'b1;
            cmd.emit_byte = repl;
        end else if (r_cnt != '0 && prefix_hit &&
                     r_cnt < xed_pkg::CntW'(xed_pkg::HoldDepth)) begin
            if (i_final) begin
                // The partial entity ends with the text: flush it all.
                cmd.held_cnt = r_cnt;
                cmd.emit_en  = 1'b1;
            end else begin
                wr_en   = 1'b1;
                wr_idx  = r_cnt;
                n_cnt   = cl;
                n_alive = match & ~len_eq;
            end
        end else begin
            // Mismatch (or nothing held): flush, then treat the byte afresh.
            cmd.held_cnt = r_cnt;
            if (i_byte == xed_pkg::ChAmp) begin
                if (i_final) begin
                    cmd.emit_en = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    n_cnt   = xed_pkg::CntW'(1);
                    n_alive = '1;
                end
            end else if (i_byte != xed_pkg::ChCr) begin
                cmd.emit_en = 1'b1;
            end
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.held_cnt != '0 || cmd.emit_en || cmd.term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_alive <= '0;
        end else if (accept) begin
            r_cnt   <= n_cnt;
            r_alive <= n_alive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            r_held[wr_idx] <= i_byte;
        end
    end

endmodule

[sv/xed_fifo.sv]
// ----------------------------------------------------------------------------
// XML entity decoder command queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module xed_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  xed_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output xed_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);

    xed_pkg::t_cmd             r_mem [xed_pkg::QDepth];
    logic [xed_pkg::QPtrW-1:0] r_wr;
    logic [xed_pkg::QPtrW-1:0] r_rd;
    logic [xed_pkg::QCntW-1:0] r_count;

    logic do_pop;

    assign o_full  = (r_count == xed_pkg::QCntW'(xed_pkg::QDepth));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + xed_pkg::QPtrW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + xed_pkg::QPtrW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + xed_pkg::QCntW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - xed_pkg::QCntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

[sv/xed_back.sv]
// ----------------------------------------------------------------------------
// XML entity decoder back end
// Expands each command into registered output bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module xed_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  xed_pkg::t_cmd i_cmd,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last
);

    logic [xed_pkg::CntW-1:0] r_pos;
    logic                     r_valid;
    logic [7:0]               r_byte;
    logic                     r_last;

    logic [xed_pkg::CntW-1:0] n_items;
    logic                     load_ok;
    logic                     step;
    logic                     at_end;
    logic [7:0]               sel_byte;
    logic                     sel_last;

    assign n_items = i_cmd.held_cnt + xed_pkg::CntW'(i_cmd.emit_en) +
                     xed_pkg::CntW'(i_cmd.term);
    assign load_ok = !r_valid || i_ready;
    assign step    = !i_empty && load_ok;
    assign at_end  = (r_pos == n_items - xed_pkg::CntW'(1));
    assign o_pop   = step && at_end;

    always_comb begin
        sel_byte = xed_pkg::ChTerm;
        sel_last = 1'b0;
        if (r_pos < i_cmd.held_cnt) begin
            sel_byte = i_cmd.held[r_pos];
        end else if (r_pos == i_cmd.held_cnt && i_cmd.emit_en) begin
            sel_byte = i_cmd.emit_byte;
        end else begin
            sel_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (step) begin
                r_valid <= 1'b1;
                r_pos   <= at_end ? '0 : r_pos + xed_pkg::CntW'(1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte <= sel_byte;
            r_last <= sel_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

[sv/xml_entity_decoder.sv]
// ----------------------------------------------------------------------------
// XML entity decoder
// Replaces &gt; &lt; &quot; &apos; &amp; by their characters and drops CR.
// ----------------------------------------------------------------------------
// Path: an input transfer's command enters the command queue; the back end then
// registers its results. Throughput: one input byte per cycle while the queue
// is not full; each result of an input byte takes one back-end output transfer,
// and the four-entry command queue absorbs the bursts after mismatches.
// Reset: synchronous, active low; clears the held count, the queue and the
// output valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
module xml_entity_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // final_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] decoded_byte
    output logic       m_axis_tlast    // last
);

    // The front end tracks which entities the held bytes still match and turns
    // every byte into at most one command; commands that produce nothing
    // (a held entity byte or a dropped carriage return) are not queued at all.
    xed_pkg::t_cmd front_cmd;
    xed_pkg::t_cmd head_cmd;
    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_empty;

    xed_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_final  (s_axis_tlast),
        .i_q_full (q_full),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    // The queue decouples the two sides so the input keeps moving while the
    // back end drains a flush of held bytes.
    xed_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // The back end walks the head command: held bytes, then the single byte,
    // then the terminator, each into the output register.
    xed_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule
